@@ design/swo_pkg.sv @@
`default_nettype none
package swo_pkg;

    localparam int WHEEL_COUNT_BITS_DEF = 10;
    localparam int STEER_COUNT_BITS_DEF = 16;

    // Shared multiply/divide unit: the second operand is always this wide.
    localparam int MD_B_W = 32;

    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_IDX_W = $clog2(CORDIC_STEPS);
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0  = CORDIC_W'(652032874);
    localparam logic signed [CORDIC_W-1:0] CORDIC_ONE = CORDIC_W'(1073741824);

    // 2^32 / (2 pi) scaled so that phi lands in bits [77:46] of q * RAD_TO_BAM.
    localparam logic [31:0] RAD_TO_BAM = 32'd683565276;
    localparam int PHI_LSB = 46;
    localparam int Q30_SHIFT = 30;

    localparam int SAT_W = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEER_ZERO   = 3'd0,
        CFG_STEER_SCALE  = 3'd1,
        CFG_WHEEL_SCALE  = 3'd2,
        CFG_WHEELBASE    = 3'd3,
        CFG_STRAIGHT_THR = 3'd4
    } t_cfg_idx;

    localparam logic [15:0] RST_STEER_ZERO   = 16'd1307;
    localparam logic [23:0] RST_STEER_SCALE  = 24'd145636;
    localparam logic [23:0] RST_WHEEL_SCALE  = 24'd194238;
    localparam logic [23:0] RST_WHEELBASE    = 24'd100925;
    localparam logic [27:0] RST_STRAIGHT_THR = 28'd683565;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_DIST,
        S_STEER,
        S_CLASS,
        S_CS1,
        S_M,
        S_Q,
        S_PHI,
        S_LC,
        S_R1Q,
        S_CS2,
        S_XM,
        S_YM,
        S_HROT,
        S_CH,
        S_RXA,
        S_RXB,
        S_RYA,
        S_RYB,
        S_UPD,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_req;

    function automatic logic [29:0] atan_bam(input logic [CORDIC_IDX_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'h20000000;
            5'd1:    v = 30'h12E4051E;
            5'd2:    v = 30'h09FB385B;
            5'd3:    v = 30'h051111D4;
            5'd4:    v = 30'h028B0D43;
            5'd5:    v = 30'h0145D7E1;
            5'd6:    v = 30'h00A2F61E;
            5'd7:    v = 30'h00517C55;
            5'd8:    v = 30'h0028BE53;
            5'd9:    v = 30'h00145F2F;
            5'd10:   v = 30'h000A2F98;
            5'd11:   v = 30'h000517CC;
            5'd12:   v = 30'h00028BE6;
            5'd13:   v = 30'h000145F3;
            5'd14:   v = 30'h0000A2FA;
            5'd15:   v = 30'h0000517D;
            5'd16:   v = 30'h000028BE;
            5'd17:   v = 30'h0000145F;
            5'd18:   v = 30'h00000A30;
            5'd19:   v = 30'h00000518;
            5'd20:   v = 30'h0000028C;
            5'd21:   v = 30'h00000146;
            5'd22:   v = 30'h000000A3;
            5'd23:   v = 30'h00000051;
            5'd24:   v = 30'h00000029;
            5'd25:   v = 30'h00000014;
            5'd26:   v = 30'h0000000A;
            5'd27:   v = 30'h00000005;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(32'sh7FFF_FFFF);
        lo = SAT_W'(32'sh8000_0000);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

@@ design/steered_wheel_odometry_core.sv @@
// The first item after reset only latches its counts. Later items take a shorter path when
// the steer angle is within the straight threshold than on an arc, where the radius division
// is skipped when the steer sine is zero. The next item is taken after the result is loaded
// into the output register; the serial multiply/divide unit and the 28-step CORDIC set the
// time. Synchronous active-low reset sets the state, pose and output valid to idle or zero and
// the config to its defaults; working and output data registers are not reset.
`default_nettype none
module steered_wheel_odometry_core import swo_pkg::*; #(
    parameter int WHEEL_COUNT_BITS = WHEEL_COUNT_BITS_DEF,
    parameter int STEER_COUNT_BITS = STEER_COUNT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [WHEEL_COUNT_BITS-1:0]   i_wheel_count,
    input  wire logic [STEER_COUNT_BITS-1:0]   i_steer_count,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [31:0]                 o_heading,
    output logic signed [31:0]                 o_pos_x,
    output logic signed [31:0]                 o_pos_y,
    output logic                               o_initial_res,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int WB     = WHEEL_COUNT_BITS;
    localparam int SB     = STEER_COUNT_BITS;
    localparam int DIST_W = WB + 24;
    localparam int A_W    = DIST_W + 31;
    localparam int P_W    = A_W + MD_B_W;
    localparam int DIFF_W = ((SB > 16) ? SB : 16) + 3;

    t_state                    r_state;
    t_state                    n_state;

    logic [15:0]               r_zero;
    logic [23:0]               r_sapc;
    logic [23:0]               r_wdpc;
    logic [23:0]               r_wb;
    logic [27:0]               r_thr;

    logic                      r_have_prev;
    logic [WB-1:0]             r_last_wheel;
    logic [SB-1:0]             r_last_steer;
    logic signed [31:0]        r_head;
    logic signed [31:0]        r_x;
    logic signed [31:0]        r_y;

    logic [WB-1:0]             r_w;
    logic [SB-1:0]             r_st;
    logic                      r_initial;
    logic [DIST_W-1:0]         r_dmag;
    logic [31:0]               r_su;
    logic [30:0]               r_cv;
    logic [30:0]               r_sv;
    logic [31:0]               r_phi;
    logic [31:0]               r_r1;
    logic [33:0]               r_xm;
    logic signed [31:0]        r_bx;
    logic signed [31:0]        r_by;
    logic [31:0]               r_hnew;
    logic signed [63:0]        r_accx;
    logic signed [63:0]        r_accy;

    logic                      r_out_valid;
    logic signed [31:0]        r_o_heading;
    logic signed [31:0]        r_o_x;
    logic signed [31:0]        r_o_y;
    logic                      r_o_init;

    t_md_req                   md_req;
    logic [A_W-1:0]            md_a;
    logic [MD_B_W-1:0]         md_b;
    logic                      md_done;
    logic [P_W-1:0]            md_prod;
    logic [A_W-1:0]            md_quot;

    logic                      cd_start;
    logic [31:0]               cd_angle;
    logic                      cd_done;
    logic signed [31:0]        c_cos;
    logic signed [31:0]        c_sin;

    logic                      in_acc;
    logic                      out_free;
    logic [WB-1:0]             d1;
    logic [WB:0]               d2;
    logic [WB-1:0]             dmag_c;
    logic                      dneg_c;
    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         diff_mag;
    logic [P_W-1:0]            steer_p;
    logic [31:0]               su_abs;
    logic                      straight;
    logic signed [DIST_W:0]    sdist;
    logic                      dist_pos;
    logic                      dist_neg;
    logic                      s_pos;
    logic                      s_neg;
    logic [23:0]               len;
    logic [31:0]               cos_abs;
    logic [31:0]               sin_abs;
    logic signed [32:0]        omc;
    logic signed [63:0]        md_p64;
    logic signed [63:0]        ym_full;
    logic signed [SAT_W-1:0]   xm_s;
    logic signed [SAT_W-1:0]   ym_s;
    logic signed [SAT_W-1:0]   bx_arc;
    logic signed [SAT_W-1:0]   by_arc;
    logic [31:0]               hnew_arc;
    logic [31:0]               bx_abs;
    logic [31:0]               by_abs;

    swo_muldiv #(.A_W(A_W)) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .i_a     (md_a),
        .i_b     (md_b),
        .o_done  (md_done),
        .o_prod  (md_prod),
        .o_quot  (md_quot)
    );

    swo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cd_start),
        .i_angle (cd_angle),
        .o_done  (cd_done),
        .o_cos   (c_cos),
        .o_sin   (c_sin)
    );

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Shortest signed wheel delta; a jump of exactly half the range does not wrap.
    always_comb begin
        d1 = (r_w > r_last_wheel) ? (r_w - r_last_wheel) : (r_last_wheel - r_w);
        d2 = {1'b1, {WB{1'b0}}} - {1'b0, d1};
        if ({1'b0, d1} > d2) begin
            dmag_c = d2[WB-1:0];
            dneg_c = !(r_w < r_last_wheel);
        end else begin
            dmag_c = d1;
            dneg_c = !(r_w > r_last_wheel);
        end
    end

    assign diff     = signed'(DIFF_W'(r_last_steer) + DIFF_W'(r_st) - DIFF_W'({r_zero, 1'b0}));
    assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign steer_p  = diff[DIFF_W-1] ? (P_W'(0) - md_prod) : md_prod;

    assign su_abs   = r_su[31] ? (32'd0 - r_su) : r_su;
    assign straight = (su_abs <= {4'd0, r_thr});
    assign sdist    = dneg_c ? -signed'({1'b0, r_dmag}) : signed'({1'b0, r_dmag});
    assign dist_pos = (r_dmag != '0) && !dneg_c;
    assign dist_neg = (r_dmag != '0) && dneg_c;
    assign s_pos    = !r_su[31] && (r_su != 32'd0);
    assign s_neg    = r_su[31];

    assign len      = (r_wb == 24'd0) ? 24'd1 : r_wb;
    assign cos_abs  = c_cos[31] ? 32'(-c_cos) : 32'(c_cos);
    assign sin_abs  = c_sin[31] ? 32'(-c_sin) : 32'(c_sin);
    assign omc      = 33'sh0_4000_0000 - 33'(c_cos);
    assign md_p64   = signed'(md_prod[63:0]);
    assign bx_abs   = r_bx[31] ? 32'(-r_bx) : 32'(r_bx);
    assign by_abs   = r_by[31] ? 32'(-r_by) : 32'(r_by);

    // Body move on an arc: the quadrant of steer sign and drive sign sets all signs.
    always_comb begin
        ym_full = c_sin[31] ? -md_p64 : md_p64;
        xm_s    = signed'(SAT_W'(r_xm));
        ym_s    = SAT_W'(ym_full >>> Q30_SHIFT);
        if (s_pos && dist_pos) begin
            bx_arc   = xm_s;
            by_arc   = ym_s;
            hnew_arc = r_head + r_phi;
        end else if (s_pos && dist_neg) begin
            bx_arc   = xm_s;
            by_arc   = -ym_s;
            hnew_arc = r_head - r_phi;
        end else if (s_neg && dist_pos) begin
            bx_arc   = -xm_s;
            by_arc   = ym_s;
            hnew_arc = r_head - r_phi;
        end else begin
            bx_arc   = -xm_s;
            by_arc   = -ym_s;
            hnew_arc = r_head + r_phi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        md_req   = '0;
        md_a     = '0;
        md_b     = '0;
        cd_start = 1'b0;
        cd_angle = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (!r_have_prev) begin
                    n_state = S_FINISH;
                end else begin
                    md_req.start = 1'b1;
                    md_a         = A_W'(dmag_c);
                    md_b         = MD_B_W'(r_wdpc);
                    n_state      = S_DIST;
                end
            end
            S_DIST: begin
                if (md_done) begin
                    md_req.start = 1'b1;
                    md_a         = A_W'(diff_mag);
                    md_b         = MD_B_W'(r_sapc);
                    n_state      = S_STEER;
                end
            end
            S_STEER: begin
                if (md_done) begin
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                if (straight) begin
                    n_state = S_HROT;
                end else begin
                    cd_start = 1'b1;
                    cd_angle = r_su;
                    n_state  = S_CS1;
                end
            end
            S_CS1: begin
                if (cd_done) begin
                    md_req.start = 1'b1;
                    md_a         = A_W'(r_dmag);
                    md_b         = cos_abs;
                    n_state      = S_M;
                end
            end
            S_M: begin
                if (md_done) begin
                    md_req.start  = 1'b1;
                    md_req.is_div = 1'b1;
                    md_a          = md_prod[A_W-1:0];
                    md_b          = MD_B_W'(len);
                    n_state       = S_Q;
                end
            end
            S_Q: begin
                if (md_done) begin
                    md_req.start = 1'b1;
                    md_a         = md_quot;
                    md_b         = RAD_TO_BAM;
                    n_state      = S_PHI;
                end
            end
            S_PHI: begin
                if (md_done) begin
                    md_req.start = 1'b1;
                    md_a         = A_W'(r_cv);
                    md_b         = MD_B_W'(len);
                    n_state      = S_LC;
                end
            end
            S_LC: begin
                if (md_done) begin
                    if (r_sv == '0) begin
                        cd_start = 1'b1;
                        cd_angle = r_phi;
                        n_state  = S_CS2;
                    end else begin
                        md_req.start  = 1'b1;
                        md_req.is_div = 1'b1;
                        md_a          = md_prod[A_W-1:0];
                        md_b          = MD_B_W'(r_sv);
                        n_state       = S_R1Q;
                    end
                end
            end
            S_R1Q: begin
                if (md_done) begin
                    cd_start = 1'b1;
                    cd_angle = r_phi;
                    n_state  = S_CS2;
                end
            end
            S_CS2: begin
                if (cd_done) begin
                    md_req.start = 1'b1;
                    md_a         = A_W'(r_r1);
                    md_b         = omc[31:0];
                    n_state      = S_XM;
                end
            end
            S_XM: begin
                if (md_done) begin
                    md_req.start = 1'b1;
                    md_a         = A_W'(r_r1);
                    md_b         = sin_abs;
                    n_state      = S_YM;
                end
            end
            S_YM: begin
                if (md_done) begin
                    n_state = S_HROT;
                end
            end
            S_HROT: begin
                cd_start = 1'b1;
                cd_angle = r_head;
                n_state  = S_CH;
            end
            S_CH: begin
                if (cd_done) begin
                    md_req.start = 1'b1;
                    md_a         = A_W'(bx_abs);
                    md_b         = cos_abs;
                    n_state      = S_RXA;
                end
            end
            S_RXA: begin
                if (md_done) begin
                    md_req.start = 1'b1;
                    md_a         = A_W'(by_abs);
                    md_b         = sin_abs;
                    n_state      = S_RXB;
                end
            end
            S_RXB: begin
                if (md_done) begin
                    md_req.start = 1'b1;
                    md_a         = A_W'(by_abs);
                    md_b         = cos_abs;
                    n_state      = S_RYA;
                end
            end
            S_RYA: begin
                if (md_done) begin
                    md_req.start = 1'b1;
                    md_a         = A_W'(bx_abs);
                    md_b         = sin_abs;
                    n_state      = S_RYB;
                end
            end
            S_RYB: begin
                if (md_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero <= RST_STEER_ZERO;
            r_sapc <= RST_STEER_SCALE;
            r_wdpc <= RST_WHEEL_SCALE;
            r_wb   <= RST_WHEELBASE;
            r_thr  <= RST_STRAIGHT_THR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_STEER_ZERO:   r_zero <= i_cfg_data[15:0];
                CFG_STEER_SCALE:  r_sapc <= i_cfg_data[23:0];
                CFG_WHEEL_SCALE:  r_wdpc <= i_cfg_data[23:0];
                CFG_WHEELBASE:    r_wb   <= i_cfg_data[23:0];
                CFG_STRAIGHT_THR: r_thr  <= i_cfg_data[27:0];
                default: ;
            endcase
        end
    end

    // Pose and last counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev  <= 1'b0;
            r_last_wheel <= '0;
            r_last_steer <= '0;
            r_head       <= '0;
            r_x          <= '0;
            r_y          <= '0;
        end else if (r_state == S_START && !r_have_prev) begin
            r_have_prev  <= 1'b1;
            r_last_wheel <= r_w;
            r_last_steer <= r_st;
        end else if (r_state == S_UPD) begin
            r_head       <= r_hnew;
            r_x          <= sat32(SAT_W'(r_x) + (r_accx >>> Q30_SHIFT));
            r_y          <= sat32(SAT_W'(r_y) + (r_accy >>> Q30_SHIFT));
            r_last_wheel <= r_w;
            r_last_steer <= r_st;
        end
    end

    // Working registers of one item.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_w  <= i_wheel_count;
                    r_st <= i_steer_count;
                end
            end
            S_START: begin
                r_initial <= !r_have_prev;
            end
            S_DIST: begin
                if (md_done) begin
                    r_dmag <= md_prod[DIST_W-1:0];
                end
            end
            S_STEER: begin
                if (md_done) begin
                    r_su <= steer_p[32:1];
                end
            end
            S_CLASS: begin
                r_bx   <= '0;
                r_by   <= sat32(SAT_W'(sdist >>> 16));
                r_hnew <= r_head;
            end
            S_CS1: begin
                if (cd_done) begin
                    r_cv <= cos_abs[30:0];
                    r_sv <= sin_abs[30:0];
                end
            end
            S_PHI: begin
                if (md_done) begin
                    r_phi <= md_prod[PHI_LSB +: 32];
                end
            end
            S_LC: begin
                if (md_done && r_sv == '0) begin
                    r_r1 <= '1;
                end
            end
            S_R1Q: begin
                if (md_done) begin
                    r_r1 <= (|md_quot[A_W-1:32]) ? '1 : md_quot[31:0];
                end
            end
            S_XM: begin
                if (md_done) begin
                    r_xm <= md_prod[63:30];
                end
            end
            S_YM: begin
                if (md_done) begin
                    r_bx   <= sat32(bx_arc);
                    r_by   <= sat32(by_arc);
                    r_hnew <= hnew_arc;
                end
            end
            S_RXA: begin
                if (md_done) begin
                    r_accx <= (r_bx[31] ^ c_cos[31]) ? -md_p64 : md_p64;
                end
            end
            S_RXB: begin
                if (md_done) begin
                    r_accx <= r_accx + ((r_by[31] ^ c_sin[31]) ? -md_p64 : md_p64);
                end
            end
            S_RYA: begin
                if (md_done) begin
                    r_accy <= (r_by[31] ^ c_cos[31]) ? -md_p64 : md_p64;
                end
            end
            S_RYB: begin
                if (md_done) begin
                    r_accy <= r_accy - ((r_bx[31] ^ c_sin[31]) ? -md_p64 : md_p64);
                end
            end
            default: ;
        endcase
    end

    // Output register: a result waits here while the next item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FINISH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && out_free) begin
            r_o_heading <= r_head;
            r_o_x       <= r_x;
            r_o_y       <= r_y;
            r_o_init    <= r_initial;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_heading     = r_o_heading;
    assign o_pos_x       = r_o_x;
    assign o_pos_y       = r_o_y;
    assign o_initial_res = r_o_init;

endmodule
`default_nettype wire

@@ design/swo_muldiv.sv @@
`default_nettype none
module swo_muldiv import swo_pkg::*; #(
    parameter int A_W = 65
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_md_req               i_req,
    input  wire logic [A_W-1:0]        i_a,
    input  wire logic [MD_B_W-1:0]     i_b,
    output logic                       o_done,
    output logic [A_W+MD_B_W-1:0]      o_prod,
    output logic [A_W-1:0]             o_quot
);

    localparam int CNT_W = $clog2(A_W);

    logic               r_busy;
    logic               r_done;
    logic               r_div;
    logic [CNT_W-1:0]   r_cnt;
    logic [A_W-1:0]     r_a;
    logic [A_W-1:0]     r_hi;
    logic [MD_B_W-1:0]  r_lo;
    logic [MD_B_W-1:0]  r_b;
    logic [MD_B_W-1:0]  r_rem;
    logic [A_W-1:0]     r_q;

    logic [A_W:0]       sum;
    logic [MD_B_W:0]    sh;
    logic [MD_B_W+1:0]  sub;
    logic               ge;

    // One bit per cycle: shift-add for products, restoring steps for quotients.
    assign sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);
    assign sh  = {r_rem, r_q[A_W-1]};
    assign sub = {1'b0, sh} - {2'b00, r_b};
    assign ge  = !sub[MD_B_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_div  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_div  <= i_req.is_div;
                r_cnt  <= i_req.is_div ? CNT_W'(A_W - 1) : CNT_W'(MD_B_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_a   <= i_a;
            r_hi  <= '0;
            r_lo  <= i_b;
            r_b   <= i_b;
            r_q   <= i_a;
            r_rem <= '0;
        end else if (r_busy) begin
            if (r_div) begin
                r_rem <= ge ? sub[MD_B_W-1:0] : sh[MD_B_W-1:0];
                r_q   <= {r_q[A_W-2:0], ge};
            end else begin
                r_hi <= sum[A_W:1];
                r_lo <= {sum[0], r_lo[MD_B_W-1:1]};
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};
    assign o_quot = r_q;

endmodule
`default_nettype wire

@@ design/swo_cordic.sv @@
`default_nettype none
module swo_cordic import swo_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [31:0]        i_angle,
    output logic                    o_done,
    output logic signed [31:0]      o_cos,
    output logic signed [31:0]      o_sin
);

    logic                           r_busy;
    logic                           r_done;
    logic                           r_neg;
    logic [CORDIC_IDX_W-1:0]        r_i;
    logic signed [CORDIC_W-1:0]     r_x;
    logic signed [CORDIC_W-1:0]     r_y;
    logic signed [CORDIC_W-1:0]     r_z;
    logic signed [31:0]             r_cos;
    logic signed [31:0]             r_sin;

    logic                           fold;
    logic [31:0]                    a_fold;
    logic signed [CORDIC_W-1:0]     xs;
    logic signed [CORDIC_W-1:0]     ys;
    logic signed [CORDIC_W-1:0]     at;
    logic signed [CORDIC_W-1:0]     nx;
    logic signed [CORDIC_W-1:0]     ny;
    logic signed [CORDIC_W-1:0]     fx;
    logic signed [CORDIC_W-1:0]     fy;
    logic signed [CORDIC_W-1:0]     cx;
    logic signed [CORDIC_W-1:0]     cy;

    // Angles in the second and third quadrant are turned by a half turn first.
    assign fold   = (i_angle[31:30] == 2'b01) || (i_angle[31:30] == 2'b10);
    assign a_fold = fold ? (i_angle + 32'h8000_0000) : i_angle;

    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        at = signed'(CORDIC_W'(atan_bam(r_i)));
        if (!r_z[CORDIC_W-1]) begin
            nx = r_x - ys;
            ny = r_y + xs;
        end else begin
            nx = r_x + ys;
            ny = r_y - xs;
        end
        fx = r_neg ? -nx : nx;
        fy = r_neg ? -ny : ny;
        if (fx > CORDIC_ONE) begin
            cx = CORDIC_ONE;
        end else if (fx < -CORDIC_ONE) begin
            cx = -CORDIC_ONE;
        end else begin
            cx = fx;
        end
        if (fy > CORDIC_ONE) begin
            cy = CORDIC_ONE;
        end else if (fy < -CORDIC_ONE) begin
            cy = -CORDIC_ONE;
        end else begin
            cy = fy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == CORDIC_IDX_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_neg <= fold;
            r_x   <= CORDIC_X0;
            r_y   <= '0;
            r_z   <= CORDIC_W'(signed'(a_fold));
        end else if (r_busy) begin
            r_x <= nx;
            r_y <= ny;
            r_z <= r_z[CORDIC_W-1] ? (r_z + at) : (r_z - at);
            if (r_i == CORDIC_IDX_W'(CORDIC_STEPS - 1)) begin
                r_cos <= cx[31:0];
                r_sin <= cy[31:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule
`default_nettype wire

@@ design/swo_checker.sv @@
`default_nettype none
module swo_checker import swo_pkg::*; (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic signed [31:0]            o_heading,
    input wire logic signed [31:0]            o_pos_x,
    input wire logic signed [31:0]            o_pos_y,
    input wire logic                          o_initial_res
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_heading)
            && $stable(o_pos_x) && $stable(o_pos_y) && $stable(o_initial_res))
        else $error("stalled result changed");

    // Only one item is worked on at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while busy");

    // The first transfer after reset only latches counts and shows the zero pose.
    a_initial_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_initial_res |-> o_heading == 0 && o_pos_x == 0 && o_pos_y == 0)
        else $error("initial result carries a nonzero pose");

    // A new result appears only at the end of an item's work.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in work");

endmodule

bind steered_wheel_odometry_core swo_checker u_swo_checker (.*);
`default_nettype wire
